/* rtl/bflmq_pkg.sv */
// Package for the bounded FIFO/LIFO message queue: sizes, item structs,
// operation and register codes, and the ring slot helper.
// No dependencies.
`default_nettype none

package bflmq_pkg;

  localparam int RING_DEPTH   = 64;
  localparam int MESSAGE_BITS = 64;
  localparam int PTR_W        = $clog2(RING_DEPTH);
  localparam int CNT_W        = $clog2(RING_DEPTH + 1);
  localparam int LIMIT_W      = 7;
  localparam int CMP_W        = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;

  // Operation codes; code 3 is unused and leaves the queue unchanged
  localparam logic [1:0] FUNC_POST  = 2'd0;
  localparam logic [1:0] FUNC_TAKE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIFO_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_DUPS  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] message_word;
  } in_item_t;

  typedef struct packed {
    logic        taken_valid;
    logic [63:0] taken_message;
    logic        dropped_oldest;
    logic        refused_duplicate;
    logic        refused_full;
    logic [6:0]  queued_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  // Slot of the entry offset places past ptr, wrapped around the ring.
  // ptr < RING_DEPTH and offset <= RING_DEPTH, so one subtract suffices.
  function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(RING_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/bflmq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module bflmq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/bounded_fifo_lifo_message_queue.sv */
// Bounded message queue, top level: control, pointers and output register.
// Depends on bflmq_pkg and bflmq_ram.
//
// A result is registered once its item has executed; execution waits while a
// stalled result holds the output register. No new item is taken while one
// executes: the ring RAM's registered read is followed by the read-modify-write
// of the pointers and the ring. Reset clears pointers, count, mode, limit and
// output valid at once and sets allow-duplicates; the ring needs no clearing.
`default_nettype none

module bounded_fifo_lifo_message_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire bflmq_pkg::in_item_t               in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output bflmq_pkg::out_item_t                   out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [bflmq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bflmq_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int PW = bflmq_pkg::PTR_W;
  localparam int CW = bflmq_pkg::CNT_W;
  localparam int MW = bflmq_pkg::MESSAGE_BITS;
  localparam int XW = bflmq_pkg::CMP_W;

  bflmq_pkg::state_e state_q, state_d;

  // Queue state
  logic [PW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;

  // Configuration registers
  logic                            lifo_q;
  logic [bflmq_pkg::LIMIT_W-1:0]   limit_q;
  logic                            allow_dup_q;

  // Item held during execution
  logic [1:0]    func_q;
  logic [MW-1:0] msg_q;

  // Output register
  logic                  out_valid_q;
  bflmq_pkg::out_item_t  out_data_q, result;

  // Ring access
  logic          accept, finish;
  logic [PW-1:0] raddr, waddr;
  logic          ram_we;
  logic [MW-1:0] rdata;
  logic [CW-1:0] newest_off;

  assign in_stall_o  = (state_q != bflmq_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Finish an item only when the output register is free or drains now
  assign finish = (state_q == bflmq_pkg::ST_EXEC) && (!out_valid_q || !out_stall_i);

  // Read address: the oldest entry for a FIFO take, else the newest entry.
  // After a drop the newest entry keeps its slot, so one address serves
  // both the duplicate check and a LIFO take.
  assign newest_off = (count_q != '0) ? (count_q - CW'(1)) : '0;

  always_comb begin
    if ((in_data_i.func == bflmq_pkg::FUNC_TAKE) && !lifo_q) begin
      raddr = oldest_q;
    end else begin
      raddr = bflmq_pkg::ring_slot(oldest_q, newest_off);
    end
  end

  // Execute the held item against the read data
  always_comb begin
    logic          drop;
    logic [CW-1:0] cnt1;
    logic [PW-1:0] old1;
    logic          dup;
    logic          full;

    result   = '0;
    oldest_d = oldest_q;
    count_d  = count_q;
    ram_we   = 1'b0;
    // The new entry goes one past the newest, whether or not a drop happened
    waddr    = bflmq_pkg::ring_slot(oldest_q, count_q);

    drop = (limit_q != '0) && (XW'(limit_q) == XW'(count_q)) && (count_q != '0);
    cnt1 = drop ? (count_q - CW'(1)) : count_q;
    old1 = drop ? bflmq_pkg::ring_slot(oldest_q, CW'(1)) : oldest_q;
    dup  = !allow_dup_q && (cnt1 != '0) && (rdata == msg_q);
    full = !dup && (cnt1 >= CW'(bflmq_pkg::RING_DEPTH));

    case (func_q)
      bflmq_pkg::FUNC_POST: begin
        result.dropped_oldest    = drop;
        result.refused_duplicate = dup;
        result.refused_full      = full;
        oldest_d = old1;
        count_d  = cnt1;
        if (!dup && !full) begin
          ram_we  = finish;
          count_d = cnt1 + CW'(1);
        end
      end
      bflmq_pkg::FUNC_TAKE: begin
        if (count_q != '0) begin
          result.taken_valid   = 1'b1;
          result.taken_message = 64'(rdata);
          count_d = count_q - CW'(1);
          if (!lifo_q) begin
            oldest_d = bflmq_pkg::ring_slot(oldest_q, CW'(1));
          end
        end
      end
      bflmq_pkg::FUNC_CLEAR: begin
        oldest_d = '0;
        count_d  = '0;
      end
      default: begin
        // Unused code: leave the queue as it is
      end
    endcase

    result.queued_count = 7'(count_d);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bflmq_pkg::ST_IDLE: if (accept) state_d = bflmq_pkg::ST_EXEC;
      bflmq_pkg::ST_EXEC: if (finish) state_d = bflmq_pkg::ST_IDLE;
      default:            state_d = bflmq_pkg::ST_IDLE;
    endcase
  end

  bflmq_ram #(
    .WIDTH(MW),
    .DEPTH(bflmq_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (msg_q),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bflmq_pkg::ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      lifo_q      <= 1'b0;
      limit_q     <= '0;
      allow_dup_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        oldest_q    <= oldest_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Idle-only configuration is up to the user; mode/limit writes empty the queue
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bflmq_pkg::REG_LIFO_MODE: begin
            lifo_q   <= cfg_wdata_i[0];
            oldest_q <= '0;
            count_q  <= '0;
          end
          bflmq_pkg::REG_SIZE_LIMIT: begin
            limit_q  <= cfg_wdata_i[bflmq_pkg::LIMIT_W-1:0];
            oldest_q <= '0;
            count_q  <= '0;
          end
          bflmq_pkg::REG_ALLOW_DUPS: allow_dup_q <= cfg_wdata_i[0];
          default: begin
            // Index beyond the register list: drop the write
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_data_i.func;
      msg_q  <= in_data_i.message_word[MW-1:0];
    end
    if (finish) begin
      out_data_q <= result;
    end
  end

endmodule

`default_nettype wire

/* rtl/bflmq_checker.sv */
// Port-level checker for the bounded message queue, bound to the top level.
// Depends on bflmq_pkg.
`default_nettype none

module bflmq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire bflmq_pkg::out_item_t              out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.queued_count <= 7'(bflmq_pkg::RING_DEPTH)))
    else $error("queued count beyond ring depth");

  a_take_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.taken_valid |->
      !(out_data_o.dropped_oldest || out_data_o.refused_duplicate ||
        out_data_o.refused_full))
    else $error("take result carries post flags");

  a_taken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.taken_valid |-> (out_data_o.taken_message == 64'd0))
    else $error("message shown without a take");

  a_refuse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.refused_duplicate && out_data_o.refused_full))
    else $error("post refused for two reasons");

endmodule

bind bounded_fifo_lifo_message_queue bflmq_checker u_bflmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
